// ===== hdl/range_distinct_count_window_assert.svh =====
// Assertion macros shared by the range distinct count window RTL
`ifndef RANGE_DISTINCT_COUNT_WINDOW_ASSERT_SVH
`define RANGE_DISTINCT_COUNT_WINDOW_ASSERT_SVH

// Check cons in the same cycle as ante
`define RDCW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdcw check failed: same-cycle property");

// Check cons in the cycle after ante
`define RDCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdcw check failed: next-cycle property");

`endif

// ===== hdl/rdcw_pkg.sv =====
// Shared types and constants of the range distinct count window block
package rdcw_pkg;

    localparam int MODE_W         = 2;
    localparam int POS_W          = 10;
    localparam int END_W          = 11;
    localparam int VAL_IN_W       = 10;
    localparam int TAG_W          = 16;
    localparam int COUNT_W        = 11;
    localparam int FREQ_W         = 11;
    localparam int VALUE_W_MAX    = 16;
    localparam int DISTINCT_W_MAX = 17;
    localparam int RECIP_SHIFT    = 20;

    localparam logic [FREQ_W-1:0]  FREQ_MAX    = 11'd2047;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_WR,
        ST_CLEAR_GO,
        ST_CLEAR_WAIT,
        ST_PLAN,
        ST_FETCH,
        ST_WAIT,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        FU_IDLE,
        FU_SWEEP,
        FU_WRITE
    } fu_state_t;

    typedef enum logic [1:0] {
        FOP_NONE,
        FOP_ENTER,
        FOP_LEAVE,
        FOP_CLEAR
    } fu_op_t;

    typedef struct packed {
        fu_op_t                 op;
        logic [VALUE_W_MAX-1:0] value;
    } fu_cmd_t;

    typedef struct packed {
        logic                      busy;
        logic [DISTINCT_W_MAX-1:0] distinct;
    } fu_stat_t;

endpackage

// ===== hdl/rdcw_if.sv =====
// Valid/ready channel interfaces for query items and answer items
interface rdcw_req_if;
    logic                             valid;
    logic                             ready;
    logic [rdcw_pkg::MODE_W-1:0]      mode;
    logic [rdcw_pkg::POS_W-1:0]       load_position;
    logic [rdcw_pkg::VAL_IN_W-1:0]    load_value;
    logic [rdcw_pkg::POS_W-1:0]       query_left;
    logic [rdcw_pkg::POS_W-1:0]       query_right;
    logic [rdcw_pkg::TAG_W-1:0]       query_tag;

    modport source (
        output valid, mode, load_position, load_value, query_left, query_right, query_tag,
        input  ready
    );
    modport sink (
        input  valid, mode, load_position, load_value, query_left, query_right, query_tag,
        output ready
    );
endinterface

interface rdcw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rdcw_pkg::TAG_W-1:0]    answer_tag;
    logic [rdcw_pkg::COUNT_W-1:0]  distinct_count;
    logic                          status;

    modport source (
        output valid, answer_tag, distinct_count, status,
        input  ready
    );
    modport sink (
        input  valid, answer_tag, distinct_count, status,
        output ready
    );
endinterface

// ===== hdl/range_distinct_count_window.sv =====
// Top level: distinct value counter over a window moved one position at a time
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------------
//  req     | in  | valid / ready    | mode, load_position, load_value, query_left/right,
//          |     |                  | query_tag
//  rsp     | out | valid / ready    | answer_tag, distinct_count, status
//  cfg     | in  | cfg_we (no wait) | cfg_wdata = element_count
//
//  Load: reciprocal multiply, fold into the value space, write; a bad range goes straight to done.
//  Query: each window step runs plan, fetch (element store read) and wait (frequency
//  read-modify-write unit) in turn, and done follows the last step.
//  Clear, and the pass after reset: about VALUE_SPACE cycles with req.ready low.
//  A finished answer waits in the output register while new items are taken; a later
//  answer holds in the done state until the register frees up.
`include "range_distinct_count_window_assert.svh"

module range_distinct_count_window #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_SPACE  = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rdcw_req_if.sink                       req,
    rdcw_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [rdcw_pkg::COUNT_W-1:0]   cfg_wdata
);

    localparam int AW     = $clog2(MAX_ELEMENTS);
    localparam int VW     = $clog2(VALUE_SPACE);
    localparam int RECIP  = (1 << rdcw_pkg::RECIP_SHIFT) / VALUE_SPACE;
    localparam int PROD_W = rdcw_pkg::VAL_IN_W + rdcw_pkg::RECIP_SHIFT;

    // sequencer and window state
    rdcw_pkg::seq_state_t         state_reg, state_next;
    logic [rdcw_pkg::POS_W-1:0]   low_reg, low_next;
    logic [rdcw_pkg::END_W-1:0]   end_reg, end_next;
    rdcw_pkg::fu_op_t             step_op_reg, step_op_next;
    logic [rdcw_pkg::COUNT_W-1:0] count_reg;

    // captured item payload
    logic [rdcw_pkg::POS_W-1:0]    lpos_reg;
    logic [rdcw_pkg::VAL_IN_W-1:0] lval_reg;
    logic                          load_ok_reg;
    logic [rdcw_pkg::POS_W-1:0]    ql_reg;
    logic [rdcw_pkg::POS_W-1:0]    qr_reg;
    logic [rdcw_pkg::TAG_W-1:0]    tag_reg;
    logic                          bad_range_reg;
    logic [PROD_W-1:0]             prod_reg;

    // answer register
    logic                          rsp_valid_reg;
    logic [rdcw_pkg::TAG_W-1:0]    rsp_tag_reg;
    logic [rdcw_pkg::COUNT_W-1:0]  rsp_count_reg;
    logic                          rsp_status_reg;

    logic                          accept;
    logic                          out_free;
    logic                          in_done;
    logic                          bad_range;
    logic [rdcw_pkg::END_W-1:0]    target_end;
    logic [rdcw_pkg::POS_W-1:0]    step_pos;
    logic [rdcw_pkg::POS_W-1:0]    quot;
    logic [rdcw_pkg::VAL_IN_W-1:0] quot_scaled;
    logic [rdcw_pkg::VAL_IN_W-1:0] rem_raw;
    logic [rdcw_pkg::VAL_IN_W-1:0] rem_fix;
    logic                          elem_we;
    logic [VW-1:0]                 elem_rdata;

    rdcw_pkg::fu_cmd_t  fu_cmd;
    rdcw_pkg::fu_stat_t fu_stat;

    assign req.ready = (state_reg == rdcw_pkg::ST_IDLE) && !fu_stat.busy;
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign in_done   = (state_reg == rdcw_pkg::ST_DONE);

    // a range is bad when reversed or beyond the loaded or stored elements
    assign bad_range = (req.query_left > req.query_right)
                    || ({1'b0, req.query_right} >= count_reg)
                    || (32'(req.query_right) >= MAX_ELEMENTS);

    assign target_end = {1'b0, qr_reg} + 1'b1;

    // fold the load value into the value space: q may come out one low, fix once
    assign quot        = prod_reg[PROD_W-1:rdcw_pkg::RECIP_SHIFT];
    assign quot_scaled = rdcw_pkg::VAL_IN_W'(32'(quot) * VALUE_SPACE);
    assign rem_raw     = lval_reg - quot_scaled;
    assign rem_fix     = (32'(rem_raw) >= VALUE_SPACE)
                       ? rem_raw - rdcw_pkg::VAL_IN_W'(VALUE_SPACE) : rem_raw;

    rdcw_elem_mem #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (VW)
    ) u_elem_mem (
        .clk     (clk),
        .wr_en   (elem_we),
        .wr_addr (AW'(lpos_reg)),
        .wr_data (VW'(rem_fix)),
        .rd_addr (AW'(step_pos)),
        .rd_data (elem_rdata)
    );

    rdcw_freq_unit #(
        .VALUE_SPACE (VALUE_SPACE)
    ) u_freq_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fu_cmd),
        .stat  (fu_stat)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rdcw_pkg::ST_IDLE;
            low_reg     <= '0;
            end_reg     <= '0;
            step_op_reg <= rdcw_pkg::FOP_NONE;
            count_reg   <= rdcw_pkg::COUNT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            low_reg     <= low_next;
            end_reg     <= end_next;
            step_op_reg <= step_op_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // answer register: load from the done state, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == rdcw_pkg::ST_DONE) && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers: capture on accept, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lpos_reg      <= req.load_position;
            lval_reg      <= req.load_value;
            load_ok_reg   <= (32'(req.load_position) < MAX_ELEMENTS);
            ql_reg        <= req.query_left;
            qr_reg        <= req.query_right;
            tag_reg       <= req.query_tag;
            bad_range_reg <= bad_range;
        end
        if (state_reg == rdcw_pkg::ST_LOAD_MUL)
        begin
            prod_reg <= PROD_W'(lval_reg) * PROD_W'(RECIP);
        end
        if ((state_reg == rdcw_pkg::ST_DONE) && out_free)
        begin
            rsp_tag_reg    <= tag_reg;
            rsp_count_reg  <= bad_range_reg ? '0 : fu_stat.distinct[rdcw_pkg::COUNT_W-1:0];
            rsp_status_reg <= bad_range_reg ? rdcw_pkg::STATUS_RANGE : rdcw_pkg::STATUS_OK;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        low_next     = low_reg;
        end_next     = end_reg;
        step_op_next = step_op_reg;
        step_pos     = low_reg;
        elem_we      = 1'b0;
        fu_cmd.op    = rdcw_pkg::FOP_NONE;
        fu_cmd.value = rdcw_pkg::VALUE_W_MAX'(elem_rdata);
        case (state_reg)
            rdcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        rdcw_pkg::MODE_LOAD:
                        begin
                            state_next = rdcw_pkg::ST_LOAD_MUL;
                        end
                        rdcw_pkg::MODE_QUERY:
                        begin
                            state_next = bad_range ? rdcw_pkg::ST_DONE : rdcw_pkg::ST_PLAN;
                        end
                        rdcw_pkg::MODE_CLEAR:
                        begin
                            low_next   = '0;
                            end_next   = '0;
                            state_next = rdcw_pkg::ST_CLEAR_GO;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rdcw_pkg::ST_LOAD_MUL:
            begin
                state_next = rdcw_pkg::ST_LOAD_WR;
            end
            rdcw_pkg::ST_LOAD_WR:
            begin
                elem_we    = load_ok_reg;
                state_next = rdcw_pkg::ST_IDLE;
            end
            rdcw_pkg::ST_CLEAR_GO:
            begin
                fu_cmd.op  = rdcw_pkg::FOP_CLEAR;
                state_next = rdcw_pkg::ST_CLEAR_WAIT;
            end
            rdcw_pkg::ST_CLEAR_WAIT:
            begin
                if (!fu_stat.busy)
                begin
                    state_next = rdcw_pkg::ST_IDLE;
                end
            end
            rdcw_pkg::ST_PLAN:
            begin
                // one edge move per step: extend low, extend high, shrink low, shrink high
                state_next = rdcw_pkg::ST_FETCH;
                if (low_reg > ql_reg)
                begin
                    low_next     = low_reg - 1'b1;
                    step_pos     = low_reg - 1'b1;
                    step_op_next = rdcw_pkg::FOP_ENTER;
                end
                else if (end_reg < target_end)
                begin
                    end_next     = end_reg + 1'b1;
                    step_pos     = end_reg[rdcw_pkg::POS_W-1:0];
                    step_op_next = rdcw_pkg::FOP_ENTER;
                end
                else if (low_reg < ql_reg)
                begin
                    low_next     = low_reg + 1'b1;
                    step_pos     = low_reg;
                    step_op_next = rdcw_pkg::FOP_LEAVE;
                end
                else if (end_reg > target_end)
                begin
                    end_next     = end_reg - 1'b1;
                    step_pos     = rdcw_pkg::POS_W'(end_reg - 1'b1);
                    step_op_next = rdcw_pkg::FOP_LEAVE;
                end
                else
                begin
                    state_next = rdcw_pkg::ST_DONE;
                end
            end
            rdcw_pkg::ST_FETCH:
            begin
                // element value is out of the store now: hand it to the update unit
                fu_cmd.op  = step_op_reg;
                state_next = rdcw_pkg::ST_WAIT;
            end
            rdcw_pkg::ST_WAIT:
            begin
                if (!fu_stat.busy)
                begin
                    state_next = rdcw_pkg::ST_PLAN;
                end
            end
            rdcw_pkg::ST_DONE:
            begin
                // hold until the answer register is free
                if (out_free)
                begin
                    state_next = rdcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.answer_tag     = rsp_tag_reg;
    assign rsp.distinct_count = rsp_count_reg;
    assign rsp.status         = rsp_status_reg;

    // window edges never cross
    `RDCW_ASSERT_SAME(a_window_order, clk, rst_n, 1'b1, ({1'b0, low_reg} <= end_reg))
    // an answer appears only out of the done state
    `RDCW_ASSERT_SAME(a_rsp_from_done, clk, rst_n, $rose(rsp_valid_reg), $past(in_done))
    // a rejected range carries a zero count
    `RDCW_ASSERT_SAME(a_bad_zero, clk, rst_n, rsp_valid_reg && rsp_status_reg, rsp_count_reg == '0)
    // each step command starts an update
    `RDCW_ASSERT_NEXT(a_step_busy, clk, rst_n, (state_reg == rdcw_pkg::ST_FETCH), fu_stat.busy)

endmodule

// ===== hdl/rdcw_elem_mem.sv =====
// Element store: one write port, one registered read port
module rdcw_elem_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rdcw_freq_unit.sv =====
// Frequency table with shared read-modify-write update unit and clearing sweep
module rdcw_freq_unit #(
    parameter int VALUE_SPACE = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rdcw_pkg::fu_cmd_t  cmd,
    output rdcw_pkg::fu_stat_t stat
);

    localparam int VW = $clog2(VALUE_SPACE);
    localparam int DW = $clog2(VALUE_SPACE + 1);
    localparam logic [VW-1:0] LAST_ADDR = VW'(VALUE_SPACE - 1);

    logic [rdcw_pkg::FREQ_W-1:0] freq_mem [VALUE_SPACE];
    logic [rdcw_pkg::FREQ_W-1:0] rd_data_reg;

    rdcw_pkg::fu_state_t state_reg, state_next;
    rdcw_pkg::fu_op_t    op_reg, op_next;
    logic [VW-1:0]       sweep_addr_reg, sweep_addr_next;
    logic [VW-1:0]       val_reg, val_next;
    logic [DW-1:0]       distinct_reg, distinct_next;

    logic                        wr_en;
    logic [VW-1:0]               wr_addr;
    logic [rdcw_pkg::FREQ_W-1:0] wr_data;
    logic [VW-1:0]               rd_addr;

    assign rd_addr = VW'(cmd.value);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            freq_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= freq_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rdcw_pkg::FU_SWEEP;
            op_reg         <= rdcw_pkg::FOP_NONE;
            sweep_addr_reg <= '0;
            distinct_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            sweep_addr_reg <= sweep_addr_next;
            distinct_reg   <= distinct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        sweep_addr_next = sweep_addr_reg;
        val_next        = val_reg;
        distinct_next   = distinct_reg;
        wr_en           = 1'b0;
        wr_addr         = val_reg;
        wr_data         = rd_data_reg;
        case (state_reg)
            rdcw_pkg::FU_SWEEP:
            begin
                // zero one entry a cycle
                wr_en   = 1'b1;
                wr_addr = sweep_addr_reg;
                wr_data = '0;
                if (sweep_addr_reg == LAST_ADDR)
                begin
                    state_next = rdcw_pkg::FU_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            rdcw_pkg::FU_IDLE:
            begin
                case (cmd.op)
                    rdcw_pkg::FOP_ENTER, rdcw_pkg::FOP_LEAVE:
                    begin
                        val_next   = rd_addr;
                        op_next    = cmd.op;
                        state_next = rdcw_pkg::FU_WRITE;
                    end
                    rdcw_pkg::FOP_CLEAR:
                    begin
                        sweep_addr_next = '0;
                        distinct_next   = '0;
                        state_next      = rdcw_pkg::FU_SWEEP;
                    end
                    default:
                    begin
                    end
                endcase
            end
            rdcw_pkg::FU_WRITE:
            begin
                if (op_reg == rdcw_pkg::FOP_ENTER)
                begin
                    // saturate at the top, count a value on its first entry
                    if (rd_data_reg != rdcw_pkg::FREQ_MAX)
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg + 1'b1;
                        if (rd_data_reg == '0)
                        begin
                            distinct_next = distinct_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    // drop a value when its last copy leaves; ignore zero
                    if (rd_data_reg != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg - 1'b1;
                        if (rd_data_reg == rdcw_pkg::FREQ_W'(1))
                        begin
                            distinct_next = distinct_reg - 1'b1;
                        end
                    end
                end
                state_next = rdcw_pkg::FU_IDLE;
            end
            default:
            begin
                state_next = rdcw_pkg::FU_IDLE;
            end
        endcase
    end

    assign stat.busy     = (state_reg != rdcw_pkg::FU_IDLE);
    assign stat.distinct = rdcw_pkg::DISTINCT_W_MAX'(distinct_reg);

endmodule

// ===== tb/sv/range_distinct_count_window_check.sv =====
// Checker for the range distinct count window: predicts each answer item and compares it
module range_distinct_count_window_check #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_SPACE  = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rdcw_req_if                          req,
    rdcw_rsp_if                          rsp,
    input  logic                         cfg_we,
    input  logic [rdcw_pkg::COUNT_W-1:0] cfg_wdata,
    output int                           mismatch_total,
    output int                           answers_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    import rdcw_pkg::*;

    typedef struct {
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
        logic               status;
    } answer_t;

    // Shadow of the block's state
    logic [VAL_IN_W-1:0] elem_mem [MAX_ELEMENTS];
    logic [FREQ_W-1:0]   freq_tbl [VALUE_SPACE];
    logic [COUNT_W-1:0]  distinct_now;
    logic [POS_W-1:0]    win_lo;
    logic [END_W-1:0]    win_hi;
    logic [COUNT_W-1:0]  elem_limit;

    answer_t expected_answers [$];
    int      fail_total;

    task automatic enter_slot(input int pos);
        int v;
        v = int'(elem_mem[pos % MAX_ELEMENTS]) % VALUE_SPACE;
        if (freq_tbl[v] < FREQ_MAX)
        begin
            freq_tbl[v] = freq_tbl[v] + 1'b1;
            if (freq_tbl[v] == 1)
                distinct_now = distinct_now + 1'b1;
        end
    endtask

    task automatic leave_slot(input int pos);
        int v;
        v = int'(elem_mem[pos % MAX_ELEMENTS]) % VALUE_SPACE;
        if (freq_tbl[v] != 0)
        begin
            freq_tbl[v] = freq_tbl[v] - 1'b1;
            if (freq_tbl[v] == 0)
                distinct_now = distinct_now - 1'b1;
        end
    endtask

    // Move the window onto [ql, qr] in the block's edge order and queue the answer
    task automatic answer_query(input logic [POS_W-1:0] ql, input logic [POS_W-1:0] qr,
                                input logic [TAG_W-1:0] tag);
        answer_t          ans;
        logic [END_W-1:0] target;
        ans.tag = tag;
        if (ql > qr || qr >= elem_limit || int'(qr) >= MAX_ELEMENTS)
        begin
            ans.count  = '0;
            ans.status = STATUS_RANGE;
        end
        else
        begin
            target = END_W'(qr) + 1'b1;
            while (win_lo > ql)
            begin
                win_lo = win_lo - 1'b1;
                enter_slot(win_lo);
            end
            while (win_hi < target)
            begin
                enter_slot(win_hi);
                win_hi = win_hi + 1'b1;
            end
            while (win_lo < ql)
            begin
                leave_slot(win_lo);
                win_lo = win_lo + 1'b1;
            end
            while (win_hi > target)
            begin
                win_hi = win_hi - 1'b1;
                leave_slot(win_hi);
            end
            ans.count  = distinct_now;
            ans.status = STATUS_OK;
        end
        expected_answers.push_back(ans);
    endtask

    task automatic flag(input string what);
        fail_total++;
        if (fail_total <= 10)
            $display("[%0t] answer mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        if (!rst_n)
        begin
            foreach (elem_mem[i])
                elem_mem[i] = '0;
            foreach (freq_tbl[i])
                freq_tbl[i] = '0;
            distinct_now = '0;
            win_lo       = '0;
            win_hi       = '0;
            elem_limit   = COUNT_RESET;
            expected_answers.delete();
            fail_total   = 0;
            mismatch_total  <= 0;
            answers_waiting <= 0;
        end
        else
        begin
            if (cfg_we)
                elem_limit = cfg_wdata;
            if (req.valid && req.ready)
            begin
                case (req.mode)
                    MODE_LOAD:
                        if (int'(req.load_position) < MAX_ELEMENTS)
                            elem_mem[req.load_position] = req.load_value;
                    MODE_QUERY:
                        answer_query(req.query_left, req.query_right, req.query_tag);
                    MODE_CLEAR:
                    begin
                        foreach (freq_tbl[i])
                            freq_tbl[i] = '0;
                        distinct_now = '0;
                        win_lo       = '0;
                        win_hi       = '0;
                    end
                    default:
                        ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                    flag($sformatf("no query pending, got tag %04h count %0d status %0b",
                                   rsp.answer_tag, rsp.distinct_count, rsp.status));
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp.answer_tag !== want.tag || rsp.distinct_count !== want.count ||
                        rsp.status !== want.status)
                        flag($sformatf({"expected tag %04h count %0d status %0b, ",
                                        "got tag %04h count %0d status %0b"},
                                       want.tag, want.count, want.status,
                                       rsp.answer_tag, rsp.distinct_count, rsp.status));
                end
            end
            mismatch_total  <= fail_total;
            answers_waiting <= expected_answers.size();
        end
    end

endmodule

// ===== tb/sv/range_distinct_count_window_tb.sv =====
// Testbench top for the range distinct count window: stimulus, answer stalls and verdict
module range_distinct_count_window_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdcw_pkg::*;

    // Mode code the block must ignore
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Quiet cycles tolerated before the run is declared hung; covers a clear
    // pass, the settle pause and the longest window walk several times over
    localparam int STALL_LIMIT      = 20000;
    // Pause before a register write: a clear may still be sweeping the table
    localparam int SETTLE_CYCLES    = 1100;
    // Keep the loaded prefix modest so window walks stay short
    localparam int PREFIX_CAP       = 320;
    localparam int RANDOM_PER_PHASE = 220;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_kind_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [COUNT_W-1:0]  cfg_wdata;
    int                  mismatch_count;
    int                  answers_waiting;

    rdcw_req_if req_ch ();
    rdcw_rsp_if rsp_ch ();

    // Stimulus bookkeeping: which positions hold a loaded element, and the
    // length of the contiguous loaded run from position zero. Valid queries
    // stay inside that run, so every position the window sweeps is loaded.
    bit loaded_map [1024];
    int prefix_len  = 0;
    int cur_limit   = 1024;
    int last_ql     = 0;
    int burst_left  = 0;
    int quiet_cycles = 0;

    range_distinct_count_window u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    range_distinct_count_window_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatch_total  (mismatch_count),
        .answers_waiting (answers_waiting)
    );

    always #10 clk = ~clk;

    // Offer one item; the sender runs in bursts and idles between them.
    // Valid is only lowered when a gap is taken, so back-to-back items keep
    // it high without a second assignment in the same step.
    task automatic put_item(input logic [MODE_W-1:0]   m,
                            input logic [POS_W-1:0]    lpos,
                            input logic [VAL_IN_W-1:0] lval,
                            input logic [POS_W-1:0]    ql,
                            input logic [POS_W-1:0]    qr,
                            input logic [TAG_W-1:0]    tag);
        int gap;
        if (burst_left == 0)
        begin
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= m;
        req_ch.load_position <= lpos;
        req_ch.load_value    <= lval;
        req_ch.query_left    <= ql;
        req_ch.query_right   <= qr;
        req_ch.query_tag     <= tag;
        // hold the item until the block takes it
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Write one element and advance the loaded prefix past it
    task automatic load_elem(input int pos, input int val);
        put_item(MODE_LOAD, POS_W'(pos), VAL_IN_W'(val), POS_W'($urandom),
                 POS_W'($urandom), TAG_W'($urandom));
        loaded_map[pos] = 1'b1;
        while (prefix_len < 1024 && loaded_map[prefix_len])
            prefix_len++;
    endtask

    task automatic ask_range(input int ql, input int qr, input int tag);
        put_item(MODE_QUERY, POS_W'($urandom), VAL_IN_W'($urandom), POS_W'(ql),
                 POS_W'(qr), TAG_W'(tag));
    endtask

    task automatic wipe();
        put_item(MODE_CLEAR, POS_W'($urandom), VAL_IN_W'($urandom), POS_W'($urandom),
                 POS_W'($urandom), TAG_W'($urandom));
    endtask

    task automatic put_unused();
        put_item(MODE_UNUSED, POS_W'($urandom), VAL_IN_W'($urandom), POS_W'($urandom),
                 POS_W'($urandom), TAG_W'($urandom));
    endtask

    // Drop valid and hold until every predicted answer has been taken. The
    // first edge is always waited out, since the checker's count is registered.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (answers_waiting != 0);
    endtask

    // Write element_count only once the block has gone quiet
    task automatic set_limit(input int v);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = v;
    endtask

    // Answer side stalls on its own schedule: free-running, random, or a
    // fixed duty pattern, each kept for a stretch of cycles
    initial
    begin : answer_stalls
        stall_kind_t pattern;
        int          span;
        int          step;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            pattern = stall_kind_t'($urandom_range(0, 2));
            span    = $urandom_range(64, 256);
            for (step = 0; step < span; step++)
            begin
                @(posedge clk);
                case (pattern)
                    STALL_NONE:   rsp_ch.ready <= 1'b1;
                    STALL_RANDOM: rsp_ch.ready <= ($urandom_range(0, 99) < 55);
                    default:      rsp_ch.ready <= ((step % 9) < 6);
                endcase
            end
        end
    end

    // Watchdog: advance on every quiet cycle, clear on any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int seed_vals [8] = '{0, 1023, 5, 5, 0, 7, 1023, 9};
        int phase;
        int n;
        int kind;
        int hi;
        int lo_q;
        int hi_q;
        int a;
        int b;

        req_ch.valid         <= 1'b0;
        req_ch.mode          <= MODE_LOAD;
        req_ch.load_position <= '0;
        req_ch.load_value    <= '0;
        req_ch.query_left    <= '0;
        req_ch.query_right   <= '0;
        req_ch.query_tag     <= '0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        rst_n                <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The settle pause also covers the clearing pass after reset.
        set_limit(int'(COUNT_RESET));
        // duplicates and both value extremes
        for (int i = 0; i < 8; i++)
            load_elem(i, seed_vals[i]);
        // top position and top value; never swept by a valid query
        load_elem(1023, 1023);
        ask_range(0, 7, 0);
        ask_range(2, 3, 16'hFFFF);
        // overwrite an element inside the window: its removal then meets
        // a value whose frequency is already zero, which is ignored
        load_elem(3, 100);
        ask_range(4, 7, $urandom);
        ask_range(0, 0, $urandom);
        // left past right, at both ends of the position range
        ask_range(1023, 0, $urandom);
        ask_range(7, 2, $urandom);
        put_unused();
        // clear, then rebuild the window from empty
        wipe();
        ask_range(1, 2, $urandom);

        // Smallest element count: only [0, 0] is in range
        set_limit(1);
        ask_range(0, 0, $urandom);
        ask_range(0, 1, $urandom);
        ask_range(1023, 1023, $urandom);

        // Random phases: full count, a random count, and full count again
        for (phase = 0; phase < 3; phase++)
        begin
            set_limit(phase == 1 ? int'($urandom_range(2, 1023)) : 1024);
            n = 0;
            while (n < RANDOM_PER_PHASE)
            begin
                // hold off once mid-phase until the answer side has caught up
                if (phase == 1 && n == RANDOM_PER_PHASE / 2)
                    drain();
                kind = $urandom_range(0, 99);
                if (kind < 15)
                begin
                    // grow the loaded prefix, or overwrite once it is long enough
                    if (prefix_len < PREFIX_CAP)
                        load_elem(prefix_len, $urandom_range(0, 1023));
                    else
                        load_elem($urandom_range(0, prefix_len - 1), $urandom_range(0, 1023));
                end
                else if (kind < 27)
                    load_elem($urandom_range(0, prefix_len - 1), $urandom_range(0, 1023));
                else if (kind < 31)
                    load_elem($urandom_range(0, 1023), $urandom_range(0, 1023));
                else if (kind < 82)
                begin
                    // valid range inside the loaded prefix and the element count;
                    // half of them step near the last one, as sorted queries would
                    hi = ((prefix_len < cur_limit) ? prefix_len : cur_limit) - 1;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        lo_q = last_ql + int'($urandom_range(0, 16)) - 8;
                        if (lo_q < 0)
                            lo_q = 0;
                        if (lo_q > hi)
                            lo_q = hi;
                        hi_q = lo_q + int'($urandom_range(0, 24));
                        if (hi_q > hi)
                            hi_q = hi;
                    end
                    else
                    begin
                        a = $urandom_range(0, hi);
                        b = $urandom_range(0, hi);
                        lo_q = (a < b) ? a : b;
                        hi_q = (a < b) ? b : a;
                    end
                    last_ql = lo_q;
                    ask_range(lo_q, hi_q, $urandom);
                end
                else if (kind < 92)
                begin
                    // broken range: beyond the element count, or left past right
                    if (cur_limit < 1024 && $urandom_range(0, 1) == 1)
                    begin
                        hi_q = $urandom_range(cur_limit, 1023);
                        lo_q = $urandom_range(0, hi_q);
                    end
                    else
                    begin
                        lo_q = $urandom_range(1, 1023);
                        hi_q = $urandom_range(0, lo_q - 1);
                    end
                    ask_range(lo_q, hi_q, $urandom);
                end
                else if (kind < 96)
                    wipe();
                else
                begin
                    // ignored by the block, so it does not count
                    put_unused();
                    n--;
                end
                n++;
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && answers_waiting == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rdcw_pkg.sv
hdl/rdcw_if.sv
hdl/rdcw_elem_mem.sv
hdl/rdcw_freq_unit.sv
hdl/range_distinct_count_window.sv
tb/sv/range_distinct_count_window_check.sv
tb/sv/range_distinct_count_window_tb.sv
